>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/bsfc_pkg.sv
// Types and constants shared by the byte stuffing codec modules.
package bsfc_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] CFG_DIRECTION   = 3'd0;
    localparam logic [2:0] CFG_FLAG_BYTE   = 3'd1;
    localparam logic [2:0] CFG_ESCAPE_BYTE = 3'd2;
    localparam logic [2:0] CFG_FLAG_SUB    = 3'd3;
    localparam logic [2:0] CFG_ESCAPE_SUB  = 3'd4;
    localparam logic [2:0] CFG_MAX_LEN     = 3'd5;

    // Direction codes.
    localparam logic DIR_ENCODE = 1'b0;
    localparam logic DIR_DECODE = 1'b1;

    // Reset values of the registers.
    localparam logic [7:0]  RST_FLAG_BYTE   = 8'd126;
    localparam logic [7:0]  RST_ESCAPE_BYTE = 8'd125;
    localparam logic [7:0]  RST_FLAG_SUB    = 8'd1;
    localparam logic [7:0]  RST_ESCAPE_SUB  = 8'd2;
    localparam logic [15:0] RST_MAX_LEN     = 16'd1024;

    // Most results one item can cause, and runs held between front and back.
    localparam int MAX_RES  = 4;
    localparam int RES_IDXW = $clog2(MAX_RES);
    localparam int QDEPTH   = 2;

    typedef struct packed {
        logic        direction;
        logic [7:0]  flag_byte;
        logic [7:0]  escape_byte;
        logic [7:0]  flag_sub;
        logic [7:0]  escape_sub;
        logic [15:0] max_len;
    } t_cfg;

    // One result item.
    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       frame_end;
        logic       frame_error;
    } t_res;

    // All results caused by one input item.
    typedef struct packed {
        t_res [MAX_RES-1:0]  res;
        logic [RES_IDXW-1:0] last_idx;
    } t_run;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic t_res mk_res(input logic [7:0] data, input logic bv,
                                    input logic fe, input logic err);
        t_res r;
        r.data        = bv ? data : 8'd0;
        r.byte_valid  = bv;
        r.frame_end   = fe;
        r.frame_error = err;
        return r;
    endfunction

endpackage

>>> src/byte_stuffing_frame_codec.sv
// Top level of the byte stuffing frame codec with its configuration registers.
//
// Input channel (i_in_valid / o_in_ready) takes one byte per item with its
// first and final frame marks. Output channel (o_out_valid / i_out_ready)
// gives result items: a byte, an end marker or an error marker, with
// o_run_last on the last result caused by an input item.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes register
// i_cfg_index with i_cfg_data; it is always ready. Unknown indexes are ignored.
// An input item yields 0 to 4 results. They pass through the run queue into
// the output register, one per cycle while the receiver is ready.
// Input items are taken every cycle while the two-run queue has room, so the
// sustained rate is set by the output register at one result per cycle while
// the receiver is ready.
// Reset restores the register defaults, closes any open frame and empties
// the queue and the output register.
// When the receiver stalls the output item holds, the queue fills, and
// o_in_ready drops until a run has been drained.
module byte_stuffing_frame_codec #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_final_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_frame_end,
    output logic        o_frame_error,
    output logic        o_run_last
);
    import bsfc_pkg::*;

    t_cfg    r_cfg;
    t_run    s_run;
    t_run    s_head;
    t_q_stat s_q_stat;
    logic    s_push;
    logic    s_pop;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.direction   <= DIR_ENCODE;
            r_cfg.flag_byte   <= RST_FLAG_BYTE;
            r_cfg.escape_byte <= RST_ESCAPE_BYTE;
            r_cfg.flag_sub    <= RST_FLAG_SUB;
            r_cfg.escape_sub  <= RST_ESCAPE_SUB;
            r_cfg.max_len     <= RST_MAX_LEN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DIRECTION:   r_cfg.direction   <= i_cfg_data[0];
                CFG_FLAG_BYTE:   r_cfg.flag_byte   <= i_cfg_data[7:0];
                CFG_ESCAPE_BYTE: r_cfg.escape_byte <= i_cfg_data[7:0];
                CFG_FLAG_SUB:    r_cfg.flag_sub    <= i_cfg_data[7:0];
                CFG_ESCAPE_SUB:  r_cfg.escape_sub  <= i_cfg_data[7:0];
                CFG_MAX_LEN:     r_cfg.max_len     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bsfc_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_final_byte (i_final_byte),
        .i_q_stat     (s_q_stat),
        .o_push       (s_push),
        .o_run        (s_run)
    );

    bsfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_run   (s_run),
        .i_pop   (s_pop),
        .o_head  (s_head),
        .o_stat  (s_q_stat)
    );

    bsfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (s_head),
        .i_q_stat      (s_q_stat),
        .o_pop         (s_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_frame_end   (o_frame_end),
        .o_frame_error (o_frame_error),
        .o_run_last    (o_run_last)
    );

endmodule

>>> src/bsfc_front.sv
// Front end: accepts input items, tracks frame state and builds result runs.
module bsfc_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bsfc_pkg::t_cfg  i_cfg,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_data_byte,
    input  logic            i_first_byte,
    input  logic            i_final_byte,
    input  bsfc_pkg::t_q_stat i_q_stat,
    output logic            o_push,
    output bsfc_pkg::t_run  o_run
);
    import bsfc_pkg::*;

    localparam int SW = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 2;
    localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic                   r_esc, n_esc;
    logic                   r_fail, n_fail;

    t_res [MAX_RES-1:0] s_res;
    logic [RES_IDXW:0]  s_n;
    logic               s_first;
    logic               s_done;
    logic               s_err;
    logic               s_special;
    logic               s_accept;
    logic [SW-1:0]      s_lim;
    logic [SW-1:0]      s_k;

    function automatic logic [COUNT_WIDTH-1:0] sat(input logic [SW-1:0] x);
        if (x > SW'(CMAX)) begin
            return CMAX;
        end
        return x[COUNT_WIDTH-1:0];
    endfunction

    assign o_in_ready = !i_q_stat.full;
    assign s_accept   = i_in_valid && o_in_ready;
    assign s_lim      = SW'(i_cfg.max_len);

    // Per-item evaluation: results in order, error result appended last
    always_comb begin
        n_count   = r_count;
        n_esc     = r_esc;
        n_fail    = r_fail;
        s_res     = '0;
        s_n       = '0;
        s_first   = i_first_byte;
        s_done    = 1'b0;
        s_err     = 1'b0;
        s_special = (i_data_byte == i_cfg.flag_byte) || (i_data_byte == i_cfg.escape_byte);
        s_k       = s_special ? SW'(2) : SW'(1);

        // new frame: explicit first byte, or a byte outside any frame
        if (s_first || (n_count == '0 && !n_fail)) begin
            n_count = '0;
            n_esc   = 1'b0;
            n_fail  = 1'b0;
            s_first = 1'b1;
        end

        if (n_fail) begin
            // rest of a failed frame is dropped
            if (i_final_byte) begin
                n_fail  = 1'b0;
                n_count = '0;
            end
            s_done = 1'b1;
        end else if (i_cfg.direction == DIR_ENCODE) begin
            if (s_first) begin
                if (SW'(n_count) + SW'(1) > s_lim) begin
                    s_err  = 1'b1;
                    s_done = 1'b1;
                end else begin
                    s_res[s_n[RES_IDXW-1:0]] = mk_res(i_cfg.flag_byte, 1'b1, 1'b0, 1'b0);
                    s_n     = s_n + 1'b1;
                    n_count = sat(SW'(n_count) + SW'(1));
                end
            end
            if (!s_done) begin
                if (SW'(n_count) + s_k > s_lim) begin
                    s_err  = 1'b1;
                    s_done = 1'b1;
                end else begin
                    if (s_special) begin
                        s_res[s_n[RES_IDXW-1:0]] =
                            mk_res(i_cfg.escape_byte, 1'b1, 1'b0, 1'b0);
                        s_n = s_n + 1'b1;
                        // flag substitution wins when flag equals escape
                        s_res[s_n[RES_IDXW-1:0]] = mk_res(
                            (i_data_byte == i_cfg.flag_byte) ? i_cfg.flag_sub
                                                             : i_cfg.escape_sub,
                            1'b1, 1'b0, 1'b0);
                        s_n = s_n + 1'b1;
                    end else begin
                        s_res[s_n[RES_IDXW-1:0]] = mk_res(i_data_byte, 1'b1, 1'b0, 1'b0);
                        s_n = s_n + 1'b1;
                    end
                    n_count = sat(SW'(n_count) + s_k);
                end
            end
            if (!s_done && i_final_byte) begin
                if (SW'(n_count) + SW'(1) > s_lim) begin
                    s_err  = 1'b1;
                    s_done = 1'b1;
                end else begin
                    s_res[s_n[RES_IDXW-1:0]] = mk_res(i_cfg.flag_byte, 1'b1, 1'b1, 1'b0);
                    s_n     = s_n + 1'b1;
                    n_count = '0;
                    n_esc   = 1'b0;
                end
            end
        end else begin
            n_count = sat(SW'(n_count) + SW'(1));
            if (SW'(n_count) >= s_lim) begin
                s_err = 1'b1;
            end else if (n_esc) begin
                // map the code after an escape back, flag_sub tested first
                if (i_data_byte == i_cfg.flag_sub) begin
                    s_res[s_n[RES_IDXW-1:0]] =
                        mk_res(i_cfg.flag_byte, 1'b1, i_final_byte, 1'b0);
                    s_n   = s_n + 1'b1;
                    n_esc = 1'b0;
                end else if (i_data_byte == i_cfg.escape_sub) begin
                    s_res[s_n[RES_IDXW-1:0]] =
                        mk_res(i_cfg.escape_byte, 1'b1, i_final_byte, 1'b0);
                    s_n   = s_n + 1'b1;
                    n_esc = 1'b0;
                end else begin
                    s_err = 1'b1;
                end
            end else if (i_data_byte == i_cfg.escape_byte) begin
                n_esc = 1'b1;
                if (i_final_byte) begin
                    // lone escape at frame end: bare end marker
                    s_res[s_n[RES_IDXW-1:0]] = mk_res(8'd0, 1'b0, 1'b1, 1'b0);
                    s_n = s_n + 1'b1;
                end
            end else begin
                s_res[s_n[RES_IDXW-1:0]] = mk_res(i_data_byte, 1'b1, i_final_byte, 1'b0);
                s_n = s_n + 1'b1;
            end
            if (!s_err && i_final_byte) begin
                n_count = '0;
                n_esc   = 1'b0;
            end
        end

        // error result after whatever this item already produced
        if (s_err) begin
            s_res[s_n[RES_IDXW-1:0]] = mk_res(8'd0, 1'b0, 1'b1, 1'b1);
            s_n   = s_n + 1'b1;
            n_esc = 1'b0;
            if (i_final_byte) begin
                n_fail  = 1'b0;
                n_count = '0;
            end else begin
                n_fail = 1'b1;
            end
        end
    end

    assign o_push         = s_accept && (s_n != '0);
    assign o_run.res      = s_res;
    assign o_run.last_idx = RES_IDXW'(s_n - 1'b1);

    // Frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_esc   <= 1'b0;
            r_fail  <= 1'b0;
        end else if (s_accept) begin
            r_count <= n_count;
            r_esc   <= n_esc;
            r_fail  <= n_fail;
        end
    end

endmodule

>>> src/bsfc_queue.sv
// Short queue of result runs between the front and back ends.
module bsfc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bsfc_pkg::t_run    i_run,
    input  logic              i_pop,
    output bsfc_pkg::t_run    o_head,
    output bsfc_pkg::t_q_stat o_stat
);
    import bsfc_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    t_run          r_mem [QDEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_level;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_level == CW'(QDEPTH));
    assign o_stat.empty = (r_level == '0);

    // Run storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

>>> src/bsfc_back.sv
// Back end: walks the head run and drives one result item per cycle while the receiver is ready and a run is queued.
module bsfc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bsfc_pkg::t_run    i_head,
    input  bsfc_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_byte_valid,
    output logic              o_frame_end,
    output logic              o_frame_error,
    output logic              o_run_last
);
    import bsfc_pkg::*;

    logic [RES_IDXW-1:0] r_idx;
    logic                r_valid;
    logic [7:0]          r_byte;
    logic                r_bvalid;
    logic                r_end;
    logic                r_err;
    logic                r_last;
    logic                s_load;
    logic                s_is_last;
    t_res                s_cur;

    assign s_cur     = i_head.res[r_idx];
    assign s_is_last = (r_idx == i_head.last_idx);
    assign s_load    = (!r_valid || i_out_ready) && !i_q_stat.empty;
    assign o_pop     = s_load && s_is_last;

    // Run position and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (s_load) begin
                r_idx   <= s_is_last ? '0 : r_idx + 1'b1;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_byte   <= s_cur.data;
            r_bvalid <= s_cur.byte_valid;
            r_end    <= s_cur.frame_end;
            r_err    <= s_cur.frame_error;
            r_last   <= s_is_last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_byte_valid  = r_bvalid;
    assign o_frame_end   = r_end;
    assign o_frame_error = r_err;
    assign o_run_last    = r_last;

endmodule

>>> src/bsfc_checker.sv
// Port-level checks of the byte stuffing codec, bound to the top level.
`include "assert_macros.svh"

module bsfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_byte_valid,
    input logic       o_frame_end,
    input logic       o_frame_error,
    input logic       o_run_last
);

    // A stalled result item holds its byte
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte), "stalled result item changed")

    // An error closes the frame and ends the run of its item
    `ASSERT_CLK(a_err_shape, i_clk, i_rst_n, o_out_valid && o_frame_error |-> o_frame_end && !o_byte_valid && o_run_last, "error result malformed")

    // A result without a byte is an end marker with a zero byte
    `ASSERT_CLK(a_bare_end, i_clk, i_rst_n, o_out_valid && !o_byte_valid |-> o_frame_end && (o_out_byte == 8'd0), "bare result is not an end marker")

    // Frame end is always the last result of its item
    `ASSERT_CLK(a_end_last, i_clk, i_rst_n, o_out_valid && o_frame_end |-> o_run_last, "frame end before end of run")

endmodule

bind byte_stuffing_frame_codec bsfc_checker u_bsfc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_byte    (o_out_byte),
    .o_byte_valid  (o_byte_valid),
    .o_frame_end   (o_frame_end),
    .o_frame_error (o_frame_error),
    .o_run_last    (o_run_last)
);

>>> verif/tb_byte_stuffing_frame_codec.sv
// Self-checking testbench for the byte stuffing frame codec: predicts and checks every result.
`timescale 1ns / 100ps

module tb_byte_stuffing_frame_codec;
    import bsfc_pkg::*;

    localparam int          CLK_PERIOD   = 8;
    localparam int          COUNT_MAX    = 65535;
    localparam int          SETTLE_GAP   = 10;
    localparam int          HOLD_CYCLES  = 200;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          RANDOM_ITEMS = 84;
    localparam int          NUM_PHASES   = 6;
    localparam logic [2:0]  CFG_UNUSED   = 3'd7;

    // One result item as seen on the output channel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       frame_error;
        logic       run_last;
    } t_codec_result;

    // Frame codec predictor with its queue of results still due from the block
    class stuffing_scoreboard;
        t_cfg            regs;
        int unsigned     frame_len;
        bit              esc_seen;
        bit              frame_dropped;
        t_codec_result   run_q[$];
        t_codec_result   results_due[$];
        int unsigned     mismatches;
        int unsigned     results_seen;

        function new();
            regs.direction   = DIR_ENCODE;
            regs.flag_byte   = RST_FLAG_BYTE;
            regs.escape_byte = RST_ESCAPE_BYTE;
            regs.flag_sub    = RST_FLAG_SUB;
            regs.escape_sub  = RST_ESCAPE_SUB;
            regs.max_len     = RST_MAX_LEN;
            frame_len     = 0;
            esc_seen      = 1'b0;
            frame_dropped = 1'b0;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                CFG_DIRECTION:   regs.direction   = data[0];
                CFG_FLAG_BYTE:   regs.flag_byte   = data[7:0];
                CFG_ESCAPE_BYTE: regs.escape_byte = data[7:0];
                CFG_FLAG_SUB:    regs.flag_sub    = data[7:0];
                CFG_ESCAPE_SUB:  regs.escape_sub  = data[7:0];
                CFG_MAX_LEN:     regs.max_len     = data;
                default: ;
            endcase
        endfunction

        function void emit(logic [7:0] b, bit bv, bit fe, bit err);
            t_codec_result r;
            r.out_byte    = bv ? b : 8'h00;
            r.byte_valid  = bv;
            r.frame_end   = fe;
            r.frame_error = err;
            r.run_last    = 1'b0;
            run_q.push_back(r);
        endfunction

        // Error marker; a final byte closes the frame, otherwise the rest is dropped
        function void abort_frame(bit fin);
            emit(8'h00, 1'b0, 1'b1, 1'b1);
            esc_seen = 1'b0;
            if (fin) begin
                frame_dropped = 1'b0;
                frame_len     = 0;
            end else begin
                frame_dropped = 1'b1;
            end
        endfunction

        function void grow(int unsigned k);
            frame_len = (frame_len + k > COUNT_MAX) ? COUNT_MAX : frame_len + k;
        endfunction

        // Works out the results of one accepted item; returns 0 when it is ignored
        function bit note_byte_in(logic [7:0] b, bit first, bit fin);
            bit          start;
            bit          ok;
            bit          special;
            int unsigned k;
            logic [7:0]  plain;
            start = first;
            ok    = 1'b1;
            run_q.delete();
            if (first || (frame_len == 0 && !frame_dropped)) begin
                frame_len     = 0;
                esc_seen      = 1'b0;
                frame_dropped = 1'b0;
                start         = 1'b1;
            end
            // rest of a failed frame
            if (frame_dropped) begin
                if (fin) begin
                    frame_dropped = 1'b0;
                    frame_len     = 0;
                end
                return 1'b0;
            end
            if (regs.direction == DIR_ENCODE) begin
                if (start) begin
                    if (frame_len + 1 > regs.max_len) begin
                        abort_frame(fin);
                        ok = 1'b0;
                    end else begin
                        emit(regs.flag_byte, 1'b1, 1'b0, 1'b0);
                        grow(1);
                    end
                end
                if (ok) begin
                    special = (b == regs.flag_byte) || (b == regs.escape_byte);
                    k = special ? 2 : 1;
                    if (frame_len + k > regs.max_len) begin
                        abort_frame(fin);
                        ok = 1'b0;
                    end else if (special) begin
                        emit(regs.escape_byte, 1'b1, 1'b0, 1'b0);
                        emit((b == regs.flag_byte) ? regs.flag_sub : regs.escape_sub,
                             1'b1, 1'b0, 1'b0);
                        grow(k);
                    end else begin
                        emit(b, 1'b1, 1'b0, 1'b0);
                        grow(k);
                    end
                end
                if (ok && fin) begin
                    if (frame_len + 1 > regs.max_len) begin
                        abort_frame(fin);
                    end else begin
                        emit(regs.flag_byte, 1'b1, 1'b1, 1'b0);
                        frame_len = 0;
                        esc_seen  = 1'b0;
                    end
                end
            end else begin
                grow(1);
                if (frame_len >= regs.max_len) begin
                    abort_frame(fin);
                    ok = 1'b0;
                end else if (esc_seen) begin
                    // flag code wins when both codes match
                    if (b == regs.flag_sub) begin
                        plain = regs.flag_byte;
                    end else if (b == regs.escape_sub) begin
                        plain = regs.escape_byte;
                    end else begin
                        abort_frame(fin);
                        ok = 1'b0;
                    end
                    if (ok) begin
                        esc_seen = 1'b0;
                        emit(plain, 1'b1, fin, 1'b0);
                    end
                end else if (b == regs.escape_byte) begin
                    esc_seen = 1'b1;
                    if (fin) emit(8'h00, 1'b0, 1'b1, 1'b0);
                end else begin
                    emit(b, 1'b1, fin, 1'b0);
                end
                if (ok && fin) begin
                    frame_len = 0;
                    esc_seen  = 1'b0;
                end
            end
            if (run_q.size() > 0) run_q[run_q.size()-1].run_last = 1'b1;
            foreach (run_q[i]) results_due.push_back(run_q[i]);
            return 1'b1;
        endfunction

        function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_codec_result got);
            t_codec_result want;
            results_seen++;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, got);
                mismatches++;
                return;
            end
            want = results_due.pop_front();
            cmp_field("out_byte", want.out_byte, got.out_byte);
            cmp_field("byte_valid", {7'd0, want.byte_valid}, {7'd0, got.byte_valid});
            cmp_field("frame_end", {7'd0, want.frame_end}, {7'd0, got.frame_end});
            cmp_field("frame_error", {7'd0, want.frame_error}, {7'd0, got.frame_error});
            cmp_field("run_last", {7'd0, want.run_last}, {7'd0, got.run_last});
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_first_byte;
    logic        i_final_byte;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_frame_end;
    logic        o_frame_error;
    logic        o_run_last;

    stuffing_scoreboard sb;
    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int          hold_gen   = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;
    int          rx_stall   = 0;
    int unsigned cycles     = 0;
    int unsigned items_taken;
    int unsigned items_ignored;
    int unsigned settings_used;

    byte_stuffing_frame_codec dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_first_byte  (i_first_byte),
        .i_final_byte  (i_final_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_frame_end   (o_frame_end),
        .o_frame_error (o_frame_error),
        .o_run_last    (o_run_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("** byte_stuffing_frame_codec: FAILED **");
            $finish;
        end
    end

    // Receiver: checks each accepted result, stalls in bursts or one long hold
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            sb.check_result({o_out_byte, o_byte_valid, o_frame_end, o_frame_error, o_run_last});
        if (hold_gen != hold_seen) begin
            hold_seen   <= hold_gen;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall    <= rx_stall - 1;
            i_out_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
            rx_stall    <= $urandom_range(0, 10);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Offers one byte item and waits for it to be taken; called at a rising edge
    task automatic send_byte(input logic [7:0] b, input bit first, input bit fin);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_first_byte <= first;
        i_final_byte <= fin;
        do @(posedge i_clk); while (!o_in_ready);
        if (sb.note_byte_in(b, first, fin)) items_taken++;
        else items_ignored++;
    endtask

    // Sender pauses until every result is in, then lets the pipeline go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_GAP) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Byte biased toward the codes that matter under the current setting
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 6))
            0: return sb.regs.flag_byte;
            1: return sb.regs.escape_byte;
            2: return sb.regs.flag_sub;
            3: return sb.regs.escape_sub;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed frames (stuffed when decoding), some with broken marks
    task automatic send_random_frame(input bit decode);
        logic [7:0] coded_q[$];
        logic [7:0] raw;
        bit         noisy;
        bit         first;
        bit         fin;
        int         len;
        noisy = ($urandom_range(0, 4) == 0);
        len   = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            raw = pick_byte();
            if (decode && !noisy &&
                (raw == sb.regs.flag_byte || raw == sb.regs.escape_byte)) begin
                coded_q.push_back(sb.regs.escape_byte);
                coded_q.push_back((raw == sb.regs.flag_byte) ? sb.regs.flag_sub
                                                              : sb.regs.escape_sub);
            end else begin
                coded_q.push_back(raw);
            end
        end
        foreach (coded_q[i]) begin
            first = (i == 0);
            fin   = (i == coded_q.size() - 1);
            if (noisy) begin
                first = ($urandom_range(0, 3) == 0);
                fin   = ($urandom_range(0, 3) == 0);
            end
            send_byte(coded_q[i], first, fin);
        end
    endtask

    initial begin
        int unsigned phase_start;
        logic [7:0]  flag;
        logic [15:0] limit;
        sb            = new();
        items_taken   = 0;
        items_ignored = 0;
        settings_used = 1;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_DIRECTION;
        i_cfg_data    = 16'h0000;
        i_in_valid    = 1'b0;
        i_data_byte   = 8'h00;
        i_first_byte  = 1'b0;
        i_final_byte  = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Encode with reset registers: stuffing, one-byte frame, stray byte, restart
        send_byte(8'h7E, 1'b1, 1'b0);
        send_byte(8'h7D, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h7E, 1'b1, 1'b1);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'h10, 1'b1, 1'b0);
        send_byte(8'h20, 1'b1, 1'b1);

        // Length overflow mid-frame, then the ignored rest of the frame
        settle();
        write_reg(CFG_MAX_LEN, 16'd4);
        send_byte(8'h7E, 1'b1, 1'b0);
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h42, 1'b0, 1'b0);
        send_byte(8'h44, 1'b0, 1'b1);

        // Error after the opening flag
        settle();
        write_reg(CFG_MAX_LEN, 16'd1);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h02, 1'b0, 1'b1);

        // Zero limit: the opening flag overflows
        settle();
        write_reg(CFG_MAX_LEN, 16'd0);
        send_byte(8'h03, 1'b1, 1'b1);

        // Closing flag overflows on the final byte
        settle();
        write_reg(CFG_MAX_LEN, 16'd2);
        send_byte(8'h11, 1'b1, 1'b1);

        // Flag equal to escape, both directions
        settle();
        write_reg(CFG_MAX_LEN, 16'd1024);
        write_reg(CFG_FLAG_BYTE, 16'h0000);
        write_reg(CFG_ESCAPE_BYTE, 16'h0000);
        write_reg(CFG_FLAG_SUB, 16'h00FF);
        write_reg(CFG_ESCAPE_SUB, 16'h00FF);
        send_byte(8'h00, 1'b1, 1'b1);
        settle();
        write_reg(CFG_DIRECTION, {15'd0, DIR_DECODE});
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);

        // Decode: unstuffing, bad escape, dangling escape, lone escape
        settle();
        write_reg(CFG_FLAG_BYTE, {8'd0, RST_FLAG_BYTE});
        write_reg(CFG_ESCAPE_BYTE, {8'd0, RST_ESCAPE_BYTE});
        write_reg(CFG_FLAG_SUB, {8'd0, RST_FLAG_SUB});
        write_reg(CFG_ESCAPE_SUB, {8'd0, RST_ESCAPE_SUB});
        send_byte(8'h10, 1'b1, 1'b0);
        send_byte(8'h7D, 1'b0, 1'b0);
        send_byte(8'h01, 1'b0, 1'b0);
        send_byte(8'h7D, 1'b0, 1'b0);
        send_byte(8'h33, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'h20, 1'b1, 1'b0);
        send_byte(8'h7D, 1'b0, 1'b1);
        send_byte(8'h7D, 1'b1, 1'b1);
        settings_used += 6;

        // Random phases, each with a fresh setting of every register
        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            flag = 8'($urandom_range(0, 255));
            case (p)
                0: limit = 16'hFFFF;
                1: limit = 16'($urandom_range(1, 6));
                2: limit = 16'd1024;
                3: limit = 16'($urandom_range(8, 40));
                4: limit = 16'($urandom_range(1, 6));
                default: limit = 16'($urandom_range(12, 60));
            endcase
            write_reg(CFG_DIRECTION, {15'd0, (p % 2 == 1) ? DIR_DECODE : DIR_ENCODE});
            write_reg(CFG_FLAG_BYTE, {8'd0, flag});
            write_reg(CFG_ESCAPE_BYTE,
                      ($urandom_range(0, 7) == 0) ? {8'd0, flag} : 16'($urandom_range(0, 255)));
            write_reg(CFG_FLAG_SUB, 16'($urandom_range(0, 255)));
            write_reg(CFG_ESCAPE_SUB, 16'($urandom_range(0, 255)));
            write_reg(CFG_MAX_LEN, limit);
            if (p == 0) write_reg(CFG_UNUSED, 16'($urandom_range(0, 65535)));
            settings_used++;

            // long receiver hold with the sender running flat out; in the last phase neither side idles
            if (p == 2) begin
                tx_idle_on = 1'b0;
                hold_gen++;
            end else if (p == NUM_PHASES - 1) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end else begin
                tx_idle_on = 1'b1;
            end

            // count every item sent, ignored ones too
            phase_start = items_taken + items_ignored;
            while (items_taken + items_ignored - phase_start < RANDOM_ITEMS / NUM_PHASES)
                send_random_frame(sb.regs.direction == DIR_DECODE);
        end

        settle();
        $display("Covered %0d byte items (%0d ignored) over %0d register settings,",
                 items_taken, items_ignored, settings_used);
        $display("encode and decode, %0d results checked, %0d mismatches.",
                 sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** byte_stuffing_frame_codec: PASSED **");
        end else begin
            $display("** byte_stuffing_frame_codec: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/bsfc_pkg.sv
src/bsfc_front.sv
src/bsfc_queue.sv
src/bsfc_back.sv
src/byte_stuffing_frame_codec.sv
src/bsfc_checker.sv
verif/tb_byte_stuffing_frame_codec.sv
